### rtl/sacp_pkg.sv
// Shared types, constants and helpers for the set-associative cache with prefetch.
package sacp_pkg;

    localparam int MAX_SETS_DEF  = 256;
    localparam int MAX_WAYS_DEF  = 16;
    localparam int ADDR_BITS_DEF = 48;

    localparam int CNT_BITS   = 32;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 5;

    localparam logic [3:0] BLK_SHIFT_RST  = 4'd6;
    localparam logic [3:0] INDEX_BITS_RST = 4'd0;
    localparam logic [4:0] WAYS_RST       = 5'd1;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_BLK_SHIFT   = 3'd0,
        CFG_INDEX_BITS  = 3'd1,
        CFG_WAYS        = 3'd2,
        CFG_REPLACE_LRU = 3'd3,
        CFG_PREFETCH_ON = 3'd4
    } cfg_reg_t;

    typedef struct packed {
        logic [3:0] blk_shift;
        logic [3:0] index_bits;
        logic [4:0] ways;
        logic       replace_lru;
        logic       prefetch_on;
    } cfg_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_DLOOK,
        ST_DCHK,
        ST_PLOOK,
        ST_PCHK,
        ST_DONE
    } state_t;

    typedef struct packed {
        logic load;
        logic mem_rd;
        logic lookup;
        logic demand;
        logic out_load;
    } cmd_t;

    typedef struct packed {
        logic row_hit;
        logic pf_on;
    } status_t;

    function automatic logic [CNT_BITS-1:0] sat_inc(input logic [CNT_BITS-1:0] c);
        return (c == {CNT_BITS{1'b1}}) ? c : c + 1'b1;
    endfunction

endpackage

### rtl/sacp_cfg_regs.sv
// Configuration register file.
module sacp_cfg_regs (
    input  logic                                 aclk,
    input  logic                                 aresetn,
    input  logic                                 cfg_valid,
    output logic                                 cfg_ready,
    input  logic [sacp_pkg::CFG_IDX_W-1:0]       cfg_index,
    input  logic [sacp_pkg::CFG_DATA_W-1:0]      cfg_data,
    output sacp_pkg::cfg_t                       cfg
);

    sacp_pkg::cfg_t cfg_reg;

    assign cfg_ready = 1'b1;
    assign cfg       = cfg_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.blk_shift   <= sacp_pkg::BLK_SHIFT_RST;
            cfg_reg.index_bits  <= sacp_pkg::INDEX_BITS_RST;
            cfg_reg.ways        <= sacp_pkg::WAYS_RST;
            cfg_reg.replace_lru <= 1'b0;
            cfg_reg.prefetch_on <= 1'b0;
        end else if (cfg_valid) begin
            unique case (cfg_index)
                sacp_pkg::CFG_BLK_SHIFT:   cfg_reg.blk_shift   <= cfg_data[3:0];
                sacp_pkg::CFG_INDEX_BITS:  cfg_reg.index_bits  <= cfg_data[3:0];
                sacp_pkg::CFG_WAYS:        cfg_reg.ways        <= cfg_data;
                sacp_pkg::CFG_REPLACE_LRU: cfg_reg.replace_lru <= cfg_data[0];
                sacp_pkg::CFG_PREFETCH_ON: cfg_reg.prefetch_on <= cfg_data[0];
                default: ;
            endcase
        end
    end

endmodule

### rtl/sacp_ctrl.sv
// Access sequencer: demand lookup, optional prefetch lookup, result hand-off.
module sacp_ctrl (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              s_valid,
    output logic              s_ready,
    output logic              m_valid,
    input  logic              m_ready,
    input  sacp_pkg::status_t status,
    output sacp_pkg::cmd_t    cmd
);

    sacp_pkg::state_t state_reg, state_next;
    logic             m_valid_reg, m_valid_next;
    logic             out_free;

    assign out_free = !m_valid_reg || m_ready;
    assign m_valid  = m_valid_reg;
    assign s_ready  = (state_reg == sacp_pkg::ST_IDLE);

    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            sacp_pkg::ST_IDLE:  if (s_valid) state_next = sacp_pkg::ST_DLOOK;
            sacp_pkg::ST_DLOOK: state_next = sacp_pkg::ST_DCHK;
            sacp_pkg::ST_DCHK: begin
                if (!status.row_hit && status.pf_on) state_next = sacp_pkg::ST_PLOOK;
                else state_next = sacp_pkg::ST_DONE;
            end
            sacp_pkg::ST_PLOOK: state_next = sacp_pkg::ST_PCHK;
            sacp_pkg::ST_PCHK:  state_next = sacp_pkg::ST_DONE;
            sacp_pkg::ST_DONE:  if (out_free) state_next = sacp_pkg::ST_IDLE;
            default:            state_next = sacp_pkg::ST_IDLE;
        endcase
    end

    always_comb begin
        cmd = '0;
        unique case (state_reg)
            sacp_pkg::ST_IDLE:  cmd.load = s_valid;
            sacp_pkg::ST_DLOOK: cmd.mem_rd = 1'b1;
            sacp_pkg::ST_DCHK: begin
                cmd.lookup = 1'b1;
                cmd.demand = 1'b1;
            end
            sacp_pkg::ST_PLOOK: cmd.mem_rd = 1'b1;
            sacp_pkg::ST_PCHK:  cmd.lookup = 1'b1;
            sacp_pkg::ST_DONE:  cmd.out_load = out_free;
            default: ;
        endcase
    end

    always_comb begin
        m_valid_next = m_valid_reg;
        if (cmd.out_load) m_valid_next = 1'b1;
        else if (m_ready) m_valid_next = 1'b0;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= sacp_pkg::ST_IDLE;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            m_valid_reg <= m_valid_next;
        end
    end

endmodule

### rtl/sacp_datapath.sv
// Address split, set row memory, tag compare and row update, counters, result registers.
module sacp_datapath #(
    parameter int MAX_SETS  = sacp_pkg::MAX_SETS_DEF,
    parameter int MAX_WAYS  = sacp_pkg::MAX_WAYS_DEF,
    parameter int ADDR_BITS = sacp_pkg::ADDR_BITS_DEF
) (
    input  logic                               aclk,
    input  logic                               aresetn,
    input  sacp_pkg::cfg_t                     cfg,
    input  sacp_pkg::cmd_t                     cmd,
    output sacp_pkg::status_t                  status,
    input  logic [ADDR_BITS-1:0]               s_address,
    input  logic                               s_is_write,
    output logic                               m_hit,
    output logic [1:0]                         m_reads_caused,
    output logic [sacp_pkg::CNT_BITS-1:0]      m_hits_total,
    output logic [sacp_pkg::CNT_BITS-1:0]      m_misses_total,
    output logic [sacp_pkg::CNT_BITS-1:0]      m_reads_total,
    output logic [sacp_pkg::CNT_BITS-1:0]      m_writes_total
);

    localparam int SET_W   = (MAX_SETS > 1) ? $clog2(MAX_SETS) : 1;
    localparam int IDX_MAX = $clog2(MAX_SETS + 1) - 1;
    localparam int CNT_W   = $clog2(MAX_WAYS + 1);
    localparam int WAY_W   = (MAX_WAYS > 1) ? $clog2(MAX_WAYS) : 1;
    localparam int CW      = sacp_pkg::CNT_BITS;

    logic [ADDR_BITS-1:0] tag_mem [MAX_SETS][MAX_WAYS];
    logic [CNT_W-1:0]     cnt_mem [MAX_SETS];
    logic [MAX_SETS-1:0]  row_valid_reg;

    logic [ADDR_BITS-1:0] addr_reg;
    logic                 wr_reg;
    logic [ADDR_BITS-1:0] row_q [MAX_WAYS];
    logic [CNT_W-1:0]     cnt_q;
    logic                 vld_q;

    logic [CW-1:0] hits_reg, misses_reg, reads_reg, writes_reg;
    logic          hit_reg;
    logic [1:0]    caused_reg;

    logic                 out_hit_reg;
    logic [1:0]           out_caused_reg;
    logic [CW-1:0]        out_hits_reg, out_misses_reg, out_reads_reg, out_writes_reg;

    logic [3:0]           eff_ib;
    logic [4:0]           tag_sh;
    logic [ADDR_BITS-1:0] shifted, set_mask, set_full, tag, blk;
    logic [SET_W-1:0]     set_idx;
    logic [31:0]          w32;
    logic [CNT_W-1:0]     w, n, nm1, n_new;
    logic [MAX_WAYS-1:0]  match;
    logic [WAY_W-1:0]     hit_idx;
    logic                 row_hit, full, do_lru;
    logic [ADDR_BITS-1:0] row_new [MAX_WAYS];

    always_comb begin
        eff_ib   = (cfg.index_bits > 4'(IDX_MAX)) ? 4'(IDX_MAX) : cfg.index_bits;
        shifted  = addr_reg >> cfg.blk_shift;
        set_mask = ~({ADDR_BITS{1'b1}} << eff_ib);
        set_full = shifted & set_mask;
        set_idx  = set_full[SET_W-1:0];
        tag_sh   = {1'b0, cfg.blk_shift} + {1'b0, eff_ib};
        tag      = addr_reg >> tag_sh;
        blk      = {{(ADDR_BITS-1){1'b0}}, 1'b1} << cfg.blk_shift;
    end

    always_comb begin
        if (cfg.ways == 5'd0) w32 = 32'd1;
        else if (32'(cfg.ways) > 32'(MAX_WAYS)) w32 = 32'(MAX_WAYS);
        else w32 = 32'(cfg.ways);
        w = w32[CNT_W-1:0];
    end

    always_comb begin
        n       = vld_q ? cnt_q : '0;
        nm1     = n - 1'b1;
        hit_idx = '0;
        for (int j = 0; j < MAX_WAYS; j++) begin
            match[j] = (row_q[j] == tag) && (CNT_W'(j) < n);
        end
        for (int j = MAX_WAYS - 1; j >= 0; j--) begin
            if (match[j]) hit_idx = WAY_W'(j);
        end
        row_hit = |match;
        full    = (n >= w);
        do_lru  = cmd.demand && cfg.replace_lru;
        n_new   = (!row_hit && !full) ? n + 1'b1 : n;
        for (int j = 0; j < MAX_WAYS; j++) begin
            row_new[j] = row_q[j];
            if (row_hit) begin
                if (do_lru && CNT_W'(j) >= CNT_W'(hit_idx) && CNT_W'(j) < nm1)
                    row_new[j] = row_q[(j + 1) % MAX_WAYS];
                else if (do_lru && CNT_W'(j) == nm1)
                    row_new[j] = tag;
            end else if (full) begin
                if (CNT_W'(j) < nm1) row_new[j] = row_q[(j + 1) % MAX_WAYS];
                else if (CNT_W'(j) == nm1) row_new[j] = tag;
            end else if (CNT_W'(j) == n) begin
                row_new[j] = tag;
            end
        end
    end

    assign status = '{row_hit: row_hit, pf_on: cfg.prefetch_on};

    always_ff @(posedge aclk) begin
        if (cmd.mem_rd) begin
            row_q <= tag_mem[set_idx];
            cnt_q <= cnt_mem[set_idx];
        end
        if (cmd.lookup) begin
            tag_mem[set_idx] <= row_new;
            cnt_mem[set_idx] <= n_new;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            row_valid_reg <= '0;
            vld_q         <= 1'b0;
        end else begin
            if (cmd.mem_rd) vld_q <= row_valid_reg[set_idx];
            if (cmd.lookup) row_valid_reg[set_idx] <= 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.load) begin
            addr_reg <= s_address;
            wr_reg   <= s_is_write;
        end else if (cmd.lookup && cmd.demand) begin
            addr_reg <= addr_reg + blk;
        end
        if (cmd.lookup && cmd.demand) begin
            hit_reg    <= row_hit;
            caused_reg <= row_hit ? 2'd0 : 2'd1;
        end else if (cmd.lookup && !row_hit) begin
            caused_reg <= 2'd2;
        end
        if (cmd.out_load) begin
            out_hit_reg    <= hit_reg;
            out_caused_reg <= caused_reg;
            out_hits_reg   <= hits_reg;
            out_misses_reg <= misses_reg;
            out_reads_reg  <= reads_reg;
            out_writes_reg <= writes_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            hits_reg   <= '0;
            misses_reg <= '0;
            reads_reg  <= '0;
            writes_reg <= '0;
        end else if (cmd.lookup) begin
            if (cmd.demand) begin
                if (wr_reg) writes_reg <= sacp_pkg::sat_inc(writes_reg);
                if (row_hit) begin
                    hits_reg <= sacp_pkg::sat_inc(hits_reg);
                end else begin
                    misses_reg <= sacp_pkg::sat_inc(misses_reg);
                    reads_reg  <= sacp_pkg::sat_inc(reads_reg);
                end
            end else if (!row_hit) begin
                reads_reg <= sacp_pkg::sat_inc(reads_reg);
            end
        end
    end

    assign m_hit          = out_hit_reg;
    assign m_reads_caused = out_caused_reg;
    assign m_hits_total   = out_hits_reg;
    assign m_misses_total = out_misses_reg;
    assign m_reads_total  = out_reads_reg;
    assign m_writes_total = out_writes_reg;

endmodule

### rtl/set_assoc_cache_with_prefetch_unit.sv
// Top level: tag-only set-associative cache with next-block prefetch.
// One access at a time: accept, row read, compare and write back, and result load when
// it hits or prefetch is off; a demand miss that triggers a prefetch repeats the row
// read and write back on the single port of the set row memory before the result load.
// The result sits in an output register; the next access is taken once the result is
// loaded there. Sets start empty right after reset, with no clearing pass. The user
// must write configuration only while idle; the block itself does not enforce it.
module set_assoc_cache_with_prefetch_unit #(
    parameter int MAX_SETS  = sacp_pkg::MAX_SETS_DEF,
    parameter int MAX_WAYS  = sacp_pkg::MAX_WAYS_DEF,
    parameter int ADDR_BITS = sacp_pkg::ADDR_BITS_DEF
) (
    input  logic                               aclk,
    input  logic                               aresetn,
    input  logic                               cfg_valid,
    output logic                               cfg_ready,
    input  logic [sacp_pkg::CFG_IDX_W-1:0]     cfg_index,
    input  logic [sacp_pkg::CFG_DATA_W-1:0]    cfg_data,
    input  logic                               s_valid,
    output logic                               s_ready,
    input  logic [ADDR_BITS-1:0]               s_address,
    input  logic                               s_is_write,
    output logic                               m_valid,
    input  logic                               m_ready,
    output logic                               m_hit,
    output logic [1:0]                         m_reads_caused,
    output logic [sacp_pkg::CNT_BITS-1:0]      m_hits_total,
    output logic [sacp_pkg::CNT_BITS-1:0]      m_misses_total,
    output logic [sacp_pkg::CNT_BITS-1:0]      m_reads_total,
    output logic [sacp_pkg::CNT_BITS-1:0]      m_writes_total
);

    sacp_pkg::cfg_t    cfg;
    sacp_pkg::cmd_t    cmd;
    sacp_pkg::status_t status;

    sacp_cfg_regs u_cfg (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .cfg       (cfg)
    );

    sacp_ctrl u_ctrl (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .status  (status),
        .cmd     (cmd)
    );

    sacp_datapath #(
        .MAX_SETS  (MAX_SETS),
        .MAX_WAYS  (MAX_WAYS),
        .ADDR_BITS (ADDR_BITS)
    ) u_dp (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .cfg            (cfg),
        .cmd            (cmd),
        .status         (status),
        .s_address      (s_address),
        .s_is_write     (s_is_write),
        .m_hit          (m_hit),
        .m_reads_caused (m_reads_caused),
        .m_hits_total   (m_hits_total),
        .m_misses_total (m_misses_total),
        .m_reads_total  (m_reads_total),
        .m_writes_total (m_writes_total)
    );

endmodule

### dv/tb_cache_checker.sv
// Checker: watches the cache channels, predicts each access result and compares.
module tb_cache_checker (
    input  logic                            aclk,
    input  logic                            aresetn,
    input  logic                            cfg_valid,
    input  logic                            cfg_ready,
    input  logic [sacp_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  logic [sacp_pkg::CFG_DATA_W-1:0] cfg_data,
    input  logic                            s_valid,
    input  logic                            s_ready,
    input  logic [47:0]                     s_address,
    input  logic                            s_is_write,
    input  logic                            m_valid,
    input  logic                            m_ready,
    input  logic                            m_hit,
    input  logic [1:0]                      m_reads_caused,
    input  logic [sacp_pkg::CNT_BITS-1:0]   m_hits_total,
    input  logic [sacp_pkg::CNT_BITS-1:0]   m_misses_total,
    input  logic [sacp_pkg::CNT_BITS-1:0]   m_reads_total,
    input  logic [sacp_pkg::CNT_BITS-1:0]   m_writes_total,
    output int                              errors,
    output int                              pending,
    output int                              hits_seen,
    output int                              misses_seen
);
    timeunit 1ns;
    timeprecision 1ps;

    typedef struct packed {
        logic          hit;
        logic [1:0]    reads;
        logic [31:0]   hits;
        logic [31:0]   misses;
        logic [31:0]   rds;
        logic [31:0]   wrs;
    } access_result_t;

    logic [47:0] tags [256][16];
    int          fill [256];
    logic [31:0] hit_cnt, miss_cnt, rd_cnt, wr_cnt;
    logic [3:0]  off_bits, idx_bits;
    logic [4:0]  way_cnt;
    logic        lru, pf;
    access_result_t expected_results[$];

    function automatic logic [31:0] bump(logic [31:0] c);
        return (c == 32'hFFFF_FFFF) ? c : c + 32'd1;
    endfunction

    function automatic bit lookup_block(logic [47:0] a, bit demand);
        int ib, s, n, w, i, j;
        logic [47:0] tag;
        ib = idx_bits;
        while (ib > 8) ib--;
        s = int'((a >> off_bits) & ((48'd1 << ib) - 48'd1));
        tag = (off_bits + ib >= 48) ? '0 : a >> (off_bits + ib);
        n = fill[s];
        w = (way_cnt == 0) ? 1 : (way_cnt > 16 ? 16 : int'(way_cnt));
        for (i = 0; i < n; i++) begin
            if (tags[s][i] == tag) begin
                if (demand && lru && i + 1 < n) begin
                    for (j = i; j < n - 1; j++) tags[s][j] = tags[s][j+1];
                    tags[s][n-1] = tag;
                end
                return 1'b1;
            end
        end
        if (n >= w) begin
            for (j = 0; j < n - 1; j++) tags[s][j] = tags[s][j+1];
            n--;
        end
        tags[s][n] = tag;
        fill[s] = n + 1;
        return 1'b0;
    endfunction

    function automatic access_result_t predict_access(logic [47:0] a, logic wr);
        access_result_t r;
        logic [47:0] nxt;
        r = '0;
        if (wr) wr_cnt = bump(wr_cnt);
        r.hit = lookup_block(a, 1'b1);
        if (r.hit) begin
            hit_cnt = bump(hit_cnt);
        end else begin
            miss_cnt = bump(miss_cnt);
            rd_cnt = bump(rd_cnt);
            r.reads = 2'd1;
            if (pf) begin
                nxt = a + (48'd1 << off_bits);
                if (!lookup_block(nxt, 1'b0)) begin
                    rd_cnt = bump(rd_cnt);
                    r.reads = 2'd2;
                end
            end
        end
        r.hits = hit_cnt;
        r.misses = miss_cnt;
        r.rds = rd_cnt;
        r.wrs = wr_cnt;
        return r;
    endfunction

    assign pending = expected_results.size();

    always @(posedge aclk) begin
        access_result_t e, got;
        if (!aresetn) begin
            foreach (fill[i]) fill[i] = 0;
            hit_cnt = 0; miss_cnt = 0; rd_cnt = 0; wr_cnt = 0;
            off_bits = sacp_pkg::BLK_SHIFT_RST;
            idx_bits = sacp_pkg::INDEX_BITS_RST;
            way_cnt = sacp_pkg::WAYS_RST;
            lru = 0; pf = 0;
            expected_results.delete();
            errors = 0; hits_seen = 0; misses_seen = 0;
        end else begin
            if (cfg_valid && cfg_ready) begin
                case (sacp_pkg::cfg_reg_t'(cfg_index))
                    sacp_pkg::CFG_BLK_SHIFT:   off_bits = cfg_data[3:0];
                    sacp_pkg::CFG_INDEX_BITS:  idx_bits = cfg_data[3:0];
                    sacp_pkg::CFG_WAYS:        way_cnt = cfg_data;
                    sacp_pkg::CFG_REPLACE_LRU: lru = cfg_data[0];
                    sacp_pkg::CFG_PREFETCH_ON: pf = cfg_data[0];
                    default: ;
                endcase
            end
            if (s_valid && s_ready)
                expected_results.push_back(predict_access(s_address, s_is_write));
            if (m_valid && m_ready) begin
                got = {m_hit, m_reads_caused, m_hits_total, m_misses_total,
                       m_reads_total, m_writes_total};
                if (expected_results.size() == 0) begin
                    $display("%0t: result with nothing expected: %h", $time, got);
                    errors++;
                end else begin
                    e = expected_results.pop_front();
                    if (got.hit) hits_seen++; else misses_seen++;
                    if (got.hit !== e.hit || got.reads !== e.reads || got.hits !== e.hits
                        || got.misses !== e.misses || got.rds !== e.rds
                        || got.wrs !== e.wrs) begin
                        $display("%0t: mismatch expected hit=%0d rd=%0d h=%0d m=%0d r=%0d w=%0d",
                                 $time, e.hit, e.reads, e.hits, e.misses, e.rds, e.wrs);
                        $display("%0t:          actual   hit=%0d rd=%0d h=%0d m=%0d r=%0d w=%0d",
                                 $time, got.hit, got.reads, got.hits, got.misses, got.rds,
                                 got.wrs);
                        errors++;
                    end
                end
            end
        end
    end
endmodule

### dv/tb_top.sv
// Testbench top: drives accesses and configuration into the cache and gives the verdict.
module tb_top;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int DW = sacp_pkg::CFG_DATA_W;

    logic aclk, aresetn;
    logic cfg_valid, cfg_ready;
    logic [sacp_pkg::CFG_IDX_W-1:0] cfg_index;
    logic [DW-1:0] cfg_data;
    logic s_valid, s_ready, s_is_write;
    logic [47:0] s_address;
    logic m_valid, m_ready, m_hit;
    logic [1:0] m_reads_caused;
    logic [31:0] m_hits_total, m_misses_total, m_reads_total, m_writes_total;
    int errors, pending, hits_seen, misses_seen;
    int cycle_count;
    bit hold_off;
    bit steady;
    int accesses_sent;
    logic [47:0] recent_addr[$];

    set_assoc_cache_with_prefetch_unit DUT (.*);

    tb_cache_checker checker_i (.*);

    initial begin
        aclk = 0;
        forever #5 aclk = ~aclk;
    end

    always @(posedge aclk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > 400000) begin
            $display("tb_top NOT OK");
            $finish;
        end
    end

    always @(posedge aclk) begin
        if (hold_off) m_ready <= 0;
        else if (steady) m_ready <= 1;
        else m_ready <= ($urandom_range(99) >= 31);
    end

    task automatic idle_gap();
        while (!steady && $urandom_range(99) < 31) begin
            s_valid <= 0;
            @(posedge aclk);
        end
    endtask

    task automatic write_reg(sacp_pkg::cfg_reg_t idx, logic [DW-1:0] val);
        cfg_valid <= 1;
        cfg_index <= idx;
        cfg_data <= val;
        @(posedge aclk);
        while (!cfg_ready) @(posedge aclk);
    endtask

    task automatic drain();
        s_valid <= 0;
        @(posedge aclk);
        while (pending != 0) @(posedge aclk);
        repeat (10) @(posedge aclk);
    endtask

    task automatic send_access(logic [47:0] a, logic wr);
        idle_gap();
        s_valid <= 1;
        s_address <= a;
        s_is_write <= wr;
        @(posedge aclk);
        while (!s_ready) @(posedge aclk);
        accesses_sent++;
        recent_addr.push_back(a);
        if (recent_addr.size() > 40) void'(recent_addr.pop_front());
    endtask

    task automatic set_mode(int ob, int ib, int w, bit l, bit p);
        drain();
        write_reg(sacp_pkg::CFG_BLK_SHIFT, DW'(ob));
        write_reg(sacp_pkg::CFG_INDEX_BITS, DW'(ib));
        write_reg(sacp_pkg::CFG_WAYS, DW'(w));
        write_reg(sacp_pkg::CFG_REPLACE_LRU, DW'(l));
        write_reg(sacp_pkg::CFG_PREFETCH_ON, DW'(p));
        cfg_valid <= 0;
    endtask

    function automatic logic [47:0] pick_addr(int ob, int ib);
        logic [47:0] a;
        int r;
        r = $urandom_range(99);
        if (r < 45 && recent_addr.size() > 0)
            a = recent_addr[$urandom_range(recent_addr.size() - 1)]
                ^ 48'($urandom_range(63));
        else if (r < 85)
            a = 48'($urandom_range((1 << (ob + ((ib > 8) ? 8 : ib) + 3)) - 1));
        else
            a = {16'($urandom), 32'($urandom)};
        return a;
    endfunction

    initial begin
        int ob, ib, w;
        bit l, p;
        aresetn = 0;
        cfg_valid = 0; cfg_index = '0; cfg_data = '0;
        s_valid = 0; s_address = '0; s_is_write = 0;
        m_ready = 0; hold_off = 0; steady = 0;
        cycle_count = 0; accesses_sent = 0;
        repeat (10) @(posedge aclk);
        aresetn <= 1;
        @(posedge aclk);

        send_access(48'h0, 1'b0);
        send_access(48'h0, 1'b1);
        send_access(48'hFFFF_FFFF_FFFF, 1'b1);
        set_mode(12, 8, 16, 1'b1, 1'b1);
        send_access(48'hFFFF_FFFF_FFFF, 1'b0);
        send_access(48'h0, 1'b1);
        send_access(48'hFFFF_FFFF_F000, 1'b0);
        set_mode(0, 15, 0, 1'b0, 1'b1);
        for (int i = 0; i < 6; i++) send_access(48'(i), 1'(i & 1));
        set_mode(15, 0, 31, 1'b1, 1'b1);
        send_access(48'hFFFF_FFFF_FFFF, 1'b0);
        send_access(48'h0, 1'b0);
        set_mode(6, 2, 4, 1'b1, 1'b0);
        for (int i = 0; i < 6; i++) send_access(48'(i * 64 * 4), 1'b0);
        send_access(48'h0, 1'b0);
        set_mode(6, 2, 2, 1'b1, 1'b0);
        send_access(48'h400, 1'b0);
        send_access(48'h0, 1'b1);

        hold_off = 1;
        fork
            begin
                repeat (300) @(posedge aclk);
                hold_off = 0;
            end
            for (int i = 0; i < 8; i++) send_access(48'(i * 8), 1'b1);
        join
        drain();

        while (accesses_sent < 1530) begin
            ob = $urandom_range(12);
            ib = $urandom_range(10);
            w = $urandom_range(17);
            l = 1'($urandom_range(1));
            p = 1'($urandom_range(1));
            set_mode(ob, ib, w, l, p);
            steady = ($urandom_range(5) == 0);
            recent_addr.delete();
            for (int i = 0; i < 100; i++)
                send_access(pick_addr(ob, ib), 1'($urandom_range(1)));
            steady = 0;
        end
        drain();
        $display("Ran %0d accesses over random geometry, replacement and prefetch settings",
                 accesses_sent);
        $display("Demand hits %0d, misses %0d", hits_seen, misses_seen);
        if (errors == 0)
            $display("tb_top OK");
        else
            $display("tb_top NOT OK");
        $finish;
    end
endmodule
